// ----- rtl/kcl_pkg.sv -----
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants of the keypad code lock door controller.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int unsigned DIGITS      = 3;
  localparam int unsigned SEC_W       = 9;
  localparam int unsigned FAIL_SAT    = 7;

  localparam logic [1:0] RST_CODE_DIGIT   = 2'd1;
  localparam logic [7:0] RST_AUTO_CLOSE   = 8'd5;
  localparam logic [2:0] RST_MAX_FAILURES = 3'd3;
  localparam logic [7:0] RST_CLOSED_POS   = 8'd45;
  localparam logic [7:0] RST_OPEN_POS     = 8'd135;

  typedef enum logic [2:0] {
    CMD_KEY       = 3'd0,
    CMD_BACKSPACE = 3'd1,
    CMD_TOGGLE    = 3'd2,
    CMD_SERVO     = 3'd3,
    CMD_SECOND    = 3'd4,
    CMD_REMOTE    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    RES_NONE         = 3'd0,
    RES_OPENED       = 3'd1,
    RES_ALREADY_OPEN = 3'd2,
    RES_REJECTED     = 3'd3,
    RES_LOCKOUT      = 3'd4
  } entry_res_t;

  typedef enum logic [2:0] {
    REG_CODE_FIRST   = 3'd0,
    REG_CODE_SECOND  = 3'd1,
    REG_CODE_THIRD   = 3'd2,
    REG_AUTO_CLOSE   = 3'd3,
    REG_MAX_FAILURES = 3'd4,
    REG_CLOSED_POS   = 3'd5,
    REG_OPEN_POS     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] code_first;
    logic [1:0] code_second;
    logic [1:0] code_third;
    logic [7:0] auto_close_seconds;
    logic [2:0] max_failures;
    logic [7:0] closed_position;
    logic [7:0] open_position;
  } cfg_t;

  typedef struct packed {
    logic [1:0] entry_count;
    logic [7:0] door_angle;
    logic       door_open;
    logic       door_moving;
    logic [2:0] entry_result;
    logic [2:0] fail_count;
    logic       post_update;
    logic       auto_close_armed;
  } status_t;

endpackage

// ----- rtl/keypad_code_lock_door_controller.sv -----
// ----------------------------------------------------------------------------
// keypad_code_lock_door_controller
// Keypad code lock with servo door ramp, lockout and auto-close timer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one event beat: a command with
//   its key value and remote request. Output channel (out_valid / out_stall)
//   returns one status beat per event, showing the state after that event.
//   Configuration writes go through cfg_valid / cfg_ready (always ready) with
//   a register index and data; write them only while no event is in flight.
//   Path: an accepted event waits in the event register; its status is then
//   captured in the status register that drives the outputs. Throughput: one
//   event per cycle while out_stall is low; single event and status registers.
//   The event register holds its beat while the status register is full and
//   stalled; in_stall then rises, and nothing is dropped.
//   Reset (synchronous, rst_n low) empties both registers, loads register
//   defaults and parks the door closed at its default angle.
// ----------------------------------------------------------------------------
module keypad_code_lock_door_controller (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_command,
  input  logic [1:0] in_key_value,
  input  logic       in_remote_open,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_entry_count,
  output logic [7:0] out_door_angle,
  output logic       out_door_open,
  output logic       out_door_moving,
  output logic [2:0] out_entry_result,
  output logic [2:0] out_fail_count,
  output logic       out_post_update,
  output logic       out_auto_close_armed,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import kcl_pkg::*;

  logic       ev_valid_r;
  logic [2:0] ev_command_r;
  logic [1:0] ev_key_r;
  logic       ev_remote_r;
  logic       out_valid_r;
  status_t    status_r;
  status_t    status;
  cfg_t       cfg;
  logic       adv;
  logic       in_acc;

  assign cfg_ready = 1'b1;
  assign adv       = ev_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = ev_valid_r && !adv;
  assign in_acc    = in_valid && !in_stall;

  kcl_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  kcl_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .command     (ev_command_r),
    .key_value   (ev_key_r),
    .remote_open (ev_remote_r),
    .cfg         (cfg),
    .status      (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        ev_valid_r <= 1'b1;
      end else if (adv) begin
        ev_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_command_r <= in_command;
      ev_key_r     <= in_key_value;
      ev_remote_r  <= in_remote_open;
    end
    if (adv) begin
      status_r <= status;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_entry_count      = status_r.entry_count;
  assign out_door_angle       = status_r.door_angle;
  assign out_door_open        = status_r.door_open;
  assign out_door_moving      = status_r.door_moving;
  assign out_entry_result     = status_r.entry_result;
  assign out_fail_count       = status_r.fail_count;
  assign out_post_update      = status_r.post_update;
  assign out_auto_close_armed = status_r.auto_close_armed;

endmodule

// ----- rtl/kcl_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// kcl_cfg_regs
// Configuration register file: code digits, timer, lockout and positions.
// ----------------------------------------------------------------------------
module kcl_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [7:0]    wr_data,
  output kcl_pkg::cfg_t cfg
);
  import kcl_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_CODE_FIRST:   cfg_nxt.code_first         = wr_data[1:0];
        REG_CODE_SECOND:  cfg_nxt.code_second        = wr_data[1:0];
        REG_CODE_THIRD:   cfg_nxt.code_third         = wr_data[1:0];
        REG_AUTO_CLOSE:   cfg_nxt.auto_close_seconds = wr_data;
        REG_MAX_FAILURES: cfg_nxt.max_failures       = wr_data[2:0];
        REG_CLOSED_POS:   cfg_nxt.closed_position    = wr_data;
        REG_OPEN_POS:     cfg_nxt.open_position      = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_first         <= RST_CODE_DIGIT;
      cfg_r.code_second        <= RST_CODE_DIGIT;
      cfg_r.code_third         <= RST_CODE_DIGIT;
      cfg_r.auto_close_seconds <= RST_AUTO_CLOSE;
      cfg_r.max_failures       <= RST_MAX_FAILURES;
      cfg_r.closed_position    <= RST_CLOSED_POS;
      cfg_r.open_position      <= RST_OPEN_POS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/kcl_step.sv -----
// ----------------------------------------------------------------------------
// kcl_step
// Lock state and the per-event update: code entry, lockout, servo ramp,
// auto-close timer and remote requests. State advances on each event beat.
// ----------------------------------------------------------------------------
module kcl_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [2:0]       command,
  input  logic [1:0]       key_value,
  input  logic             remote_open,
  input  kcl_pkg::cfg_t    cfg,
  output kcl_pkg::status_t status
);
  import kcl_pkg::*;

  logic [1:0]       digits_r [DIGITS];
  logic [1:0]       digits_nxt [DIGITS];
  logic [1:0]       idx_r, idx_nxt;
  logic [2:0]       fail_r, fail_nxt;
  logic [7:0]       angle_r, angle_nxt;
  logic             target_r, target_nxt;
  logic             travel_r, travel_nxt;
  logic             timer_r, timer_nxt;
  logic [SEC_W-1:0] sec_r, sec_nxt;
  logic             last_r, last_nxt;
  logic [2:0]       result;
  logic             post;

  always_comb begin
    logic       match;
    logic [7:0] goal;
    for (int i = 0; i < DIGITS; i++) digits_nxt[i] = digits_r[i];
    idx_nxt    = idx_r;
    fail_nxt   = fail_r;
    angle_nxt  = angle_r;
    target_nxt = target_r;
    travel_nxt = travel_r;
    timer_nxt  = timer_r;
    sec_nxt    = sec_r;
    last_nxt   = last_r;
    result     = RES_NONE;
    post       = 1'b0;
    match      = 1'b0;
    goal       = target_r ? cfg.open_position : cfg.closed_position;

    unique case (cmd_t'(command))
      CMD_KEY: begin
        if (idx_r < 2'd3) begin
          digits_nxt[idx_r] = key_value;
          idx_nxt = idx_r + 2'd1;
        end
        if (idx_nxt == 2'd3) begin
          match = (digits_nxt[0] == cfg.code_first) &&
                  (digits_nxt[1] == cfg.code_second) &&
                  (digits_nxt[2] == cfg.code_third);
          idx_nxt = 2'd0;
          if (match) begin
            fail_nxt = 3'd0;
            if (!target_r) begin
              travel_nxt = 1'b1;
              target_nxt = 1'b1;
              result     = RES_OPENED;
              post       = 1'b1;
            end else begin
              travel_nxt = 1'b0;
              result     = RES_ALREADY_OPEN;
            end
          end else begin
            if (fail_r < 3'(FAIL_SAT)) fail_nxt = fail_r + 3'd1;
            if (fail_nxt >= cfg.max_failures) begin
              travel_nxt = 1'b1;
              target_nxt = 1'b0;
              fail_nxt   = 3'd0;
              result     = RES_LOCKOUT;
            end else begin
              result = RES_REJECTED;
            end
          end
        end
      end
      CMD_BACKSPACE: begin
        if (idx_r != 2'd0) begin
          idx_nxt = idx_r - 2'd1;
          digits_nxt[idx_nxt] = 2'd0;
        end
      end
      CMD_TOGGLE: begin
        travel_nxt = 1'b1;
        target_nxt = !target_r;
        post       = 1'b1;
      end
      CMD_SERVO: begin
        if (travel_r) begin
          if (angle_r < goal) begin
            angle_nxt = angle_r + 8'd1;
          end else if (angle_r > goal) begin
            angle_nxt = angle_r - 8'd1;
          end else begin
            travel_nxt = 1'b0;
            if (target_r) timer_nxt = 1'b1;
          end
        end
      end
      CMD_SECOND: begin
        if (timer_r) begin
          if (!target_r) begin
            timer_nxt = 1'b0;
            sec_nxt   = '0;
          end else begin
            sec_nxt = sec_r + SEC_W'(1);
            if (sec_nxt >= ({1'b0, cfg.auto_close_seconds} + SEC_W'(1))) begin
              timer_nxt  = 1'b0;
              travel_nxt = 1'b1;
              target_nxt = 1'b0;
              sec_nxt    = '0;
              post       = 1'b1;
            end
          end
        end
      end
      CMD_REMOTE: begin
        if (angle_r == cfg.open_position || angle_r == cfg.closed_position) begin
          target_nxt = remote_open;
        end
        if (target_nxt != last_r) begin
          travel_nxt = 1'b1;
          last_nxt   = target_nxt;
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGITS; i++) digits_r[i] <= 2'd0;
      idx_r    <= 2'd0;
      fail_r   <= 3'd0;
      angle_r  <= RST_CLOSED_POS;
      target_r <= 1'b0;
      travel_r <= 1'b0;
      timer_r  <= 1'b0;
      sec_r    <= '0;
      last_r   <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < DIGITS; i++) digits_r[i] <= digits_nxt[i];
      idx_r    <= idx_nxt;
      fail_r   <= fail_nxt;
      angle_r  <= angle_nxt;
      target_r <= target_nxt;
      travel_r <= travel_nxt;
      timer_r  <= timer_nxt;
      sec_r    <= sec_nxt;
      last_r   <= last_nxt;
    end
  end

  always_comb begin
    status.entry_count      = idx_nxt;
    status.door_angle       = angle_nxt;
    status.door_open        = target_nxt;
    status.door_moving      = travel_nxt;
    status.entry_result     = result;
    status.fail_count       = fail_nxt;
    status.post_update      = post;
    status.auto_close_armed = timer_nxt;
  end

endmodule

// ----- rtl/kcl_checker.sv -----
// ----------------------------------------------------------------------------
// kcl_checker
// Port-level checks of the keypad code lock door controller.
// ----------------------------------------------------------------------------
module kcl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_entry_count,
  input logic [7:0] out_door_angle,
  input logic       out_door_open,
  input logic       out_door_moving,
  input logic [2:0] out_entry_result,
  input logic [2:0] out_fail_count,
  input logic       out_post_update
);
  import kcl_pkg::*;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("status beat present right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_door_angle)
      && $stable(out_entry_result) && $stable(out_entry_count))
    else $error("stalled status beat changed");

  a_opened: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_result == RES_OPENED |->
      out_door_open && out_door_moving && out_post_update)
    else $error("accepted code without opening door");

  a_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_result == RES_LOCKOUT |->
      !out_door_open && out_fail_count == 3'd0 && !out_post_update)
    else $error("lockout did not close door or clear misses");

  a_entry_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_result != RES_NONE |-> out_entry_count == 2'd0)
    else $error("digits not cleared after code check");

endmodule

bind keypad_code_lock_door_controller kcl_checker u_kcl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_entry_count   (out_entry_count),
  .out_door_angle    (out_door_angle),
  .out_door_open     (out_door_open),
  .out_door_moving   (out_door_moving),
  .out_entry_result  (out_entry_result),
  .out_fail_count    (out_fail_count),
  .out_post_update   (out_post_update)
);

// ----- verif/keypad_code_lock_door_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_door_controller testbench
// Drives keypad, timer, servo and remote events through the event channel and
// checks every status beat against a cycle-free model of the lock kept in the
// bench. Covers code entry and backspace, lockout, servo ramps from either
// side, auto-close, remote requests and unused commands over several register
// settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import kcl_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_command = CMD_KEY;
  logic [1:0] in_key_value = 2'd0;
  logic       in_remote_open = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_entry_count;
  logic [7:0] out_door_angle;
  logic       out_door_open;
  logic       out_door_moving;
  logic [2:0] out_entry_result;
  logic [2:0] out_fail_count;
  logic       out_post_update;
  logic       out_auto_close_armed;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = REG_CODE_FIRST;
  logic [7:0] cfg_data = 8'd0;

  keypad_code_lock_door_controller i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_key_value         (in_key_value),
    .in_remote_open       (in_remote_open),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_entry_count      (out_entry_count),
    .out_door_angle       (out_door_angle),
    .out_door_open        (out_door_open),
    .out_door_moving      (out_door_moving),
    .out_entry_result     (out_entry_result),
    .out_fail_count       (out_fail_count),
    .out_post_update      (out_post_update),
    .out_auto_close_armed (out_auto_close_armed),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #2 clk = ~clk;

  // Lock model state and settings
  cfg_t       lock_cfg = '{RST_CODE_DIGIT, RST_CODE_DIGIT, RST_CODE_DIGIT, RST_AUTO_CLOSE,
                           RST_MAX_FAILURES, RST_CLOSED_POS, RST_OPEN_POS};
  logic [1:0] code_buf [DIGITS] = '{2'd0, 2'd0, 2'd0};
  int         code_len = 0;
  int         miss_count = 0;
  logic [7:0] angle = RST_CLOSED_POS;
  logic       want_open = 1'b0;
  logic       travelling = 1'b0;
  logic       timer_on = 1'b0;
  int         timer_secs = 0;
  logic       told_open = 1'b0;

  status_t    pending_status [$];
  status_t    seen, want;
  int         max_wait = 5;
  int         stall_left = 0;
  int         sent_items = 0;
  int         beats_checked = 0;
  int         mismatches = 0;
  int         settings_loaded = 0;
  int         opened_count = 0;
  int         lockout_count = 0;
  int         auto_close_count = 0;

  function automatic status_t predict_status(input logic [2:0] cmd, input logic [1:0] key,
                                             input logic rmt);
    status_t    s;
    logic [7:0] goal;
    logic       match;
    s.entry_result = RES_NONE;
    s.post_update  = 1'b0;
    case (cmd)
      CMD_KEY: begin
        if (code_len < DIGITS) begin
          code_buf[code_len] = key;
          code_len++;
        end
        if (code_len >= DIGITS) begin
          code_len = 0;
          match = code_buf[0] == lock_cfg.code_first && code_buf[1] == lock_cfg.code_second &&
                  code_buf[2] == lock_cfg.code_third;
          if (match) begin
            miss_count = 0;
            if (!want_open) begin
              travelling = 1'b1;
              want_open = 1'b1;
              s.entry_result = RES_OPENED;
              s.post_update = 1'b1;
              opened_count++;
            end else begin
              travelling = 1'b0;
              s.entry_result = RES_ALREADY_OPEN;
            end
          end else begin
            if (miss_count < FAIL_SAT) miss_count++;
            if (miss_count >= lock_cfg.max_failures) begin
              travelling = 1'b1;
              want_open = 1'b0;
              miss_count = 0;
              s.entry_result = RES_LOCKOUT;
              lockout_count++;
            end else begin
              s.entry_result = RES_REJECTED;
            end
          end
        end
      end
      CMD_BACKSPACE: begin
        if (code_len > 0) begin
          code_len--;
          code_buf[code_len] = 2'd0;
        end
      end
      CMD_TOGGLE: begin
        travelling = 1'b1;
        want_open = !want_open;
        s.post_update = 1'b1;
      end
      CMD_SERVO: begin
        if (travelling) begin
          goal = want_open ? lock_cfg.open_position : lock_cfg.closed_position;
          if (angle < goal) begin
            angle++;
          end else if (angle > goal) begin
            angle--;
          end else begin
            travelling = 1'b0;
            if (want_open) timer_on = 1'b1;
          end
        end
      end
      CMD_SECOND: begin
        if (timer_on) begin
          if (!want_open) begin
            timer_on = 1'b0;
            timer_secs = 0;
          end else begin
            timer_secs++;
            if (timer_secs >= int'(lock_cfg.auto_close_seconds) + 1) begin
              timer_on = 1'b0;
              travelling = 1'b1;
              want_open = 1'b0;
              timer_secs = 0;
              s.post_update = 1'b1;
              auto_close_count++;
            end
          end
        end
      end
      CMD_REMOTE: begin
        if (angle == lock_cfg.open_position || angle == lock_cfg.closed_position)
          want_open = rmt;
        if (want_open != told_open) begin
          travelling = 1'b1;
          told_open = want_open;
        end
      end
      default: ;
    endcase
    s.entry_count      = 2'(code_len);
    s.door_angle       = angle;
    s.door_open        = want_open;
    s.door_moving      = travelling;
    s.fail_count       = 3'(miss_count);
    s.auto_close_armed = timer_on;
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_entry_count, out_door_angle, out_door_open, out_door_moving,
              out_entry_result, out_fail_count, out_post_update, out_auto_close_armed};
      if (pending_status.size() == 0) begin
        report_mismatch("status beat with no event outstanding");
      end else begin
        want = pending_status.pop_front();
        beats_checked++;
        if (seen.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    seen.entry_count, want.entry_count));
        if (seen.door_angle !== want.door_angle)
          report_mismatch($sformatf("door_angle %0d, expected %0d",
                                    seen.door_angle, want.door_angle));
        if (seen.door_open !== want.door_open)
          report_mismatch($sformatf("door_open %0b, expected %0b",
                                    seen.door_open, want.door_open));
        if (seen.door_moving !== want.door_moving)
          report_mismatch($sformatf("door_moving %0b, expected %0b",
                                    seen.door_moving, want.door_moving));
        if (seen.entry_result !== want.entry_result)
          report_mismatch($sformatf("entry_result %0d, expected %0d",
                                    seen.entry_result, want.entry_result));
        if (seen.fail_count !== want.fail_count)
          report_mismatch($sformatf("fail_count %0d, expected %0d",
                                    seen.fail_count, want.fail_count));
        if (seen.post_update !== want.post_update)
          report_mismatch($sformatf("post_update %0b, expected %0b",
                                    seen.post_update, want.post_update));
        if (seen.auto_close_armed !== want.auto_close_armed)
          report_mismatch($sformatf("auto_close_armed %0b, expected %0b",
                                    seen.auto_close_armed, want.auto_close_armed));
      end
      stall_left = $urandom_range(0, max_wait);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= rst_n && (stall_left > 0);
  end

  task automatic send_event(input logic [2:0] cmd, input logic [1:0] key, input logic rmt);
    int gap;
    gap = $urandom_range(0, max_wait);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_key_value   <= key;
    in_remote_open <= rmt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_status.push_back(predict_status(cmd, key, rmt));
    sent_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    wait_idle();
    write_reg(REG_CODE_FIRST, 8'(s.code_first));
    write_reg(REG_CODE_SECOND, 8'(s.code_second));
    write_reg(REG_CODE_THIRD, 8'(s.code_third));
    write_reg(REG_AUTO_CLOSE, s.auto_close_seconds);
    write_reg(REG_MAX_FAILURES, 8'(s.max_failures));
    write_reg(REG_CLOSED_POS, s.closed_position);
    write_reg(REG_OPEN_POS, s.open_position);
    cfg_valid <= 1'b0;
    lock_cfg = s;
    settings_loaded++;
  endtask

  // Door end positions a few degrees around the current angle keep ramps short.
  function automatic cfg_t short_travel(input logic reversed);
    cfg_t       s;
    int         v;
    logic [7:0] lo, hi;
    v = int'($urandom_range(0, 4));
    v = v + angle - 2;
    if (v < 0) v = 0;
    if (v > 249) v = 249;
    lo = 8'(v);
    hi = lo + 8'($urandom_range(1, 6));
    s.code_first         = 2'($urandom_range(1, 3));
    s.code_second        = 2'($urandom_range(1, 3));
    s.code_third         = 2'($urandom_range(1, 3));
    s.auto_close_seconds = 8'($urandom_range(0, 3));
    s.max_failures       = 3'($urandom_range(1, 4));
    s.closed_position    = reversed ? hi : lo;
    s.open_position      = reversed ? lo : hi;
    return s;
  endfunction

  task automatic enter_code();
    logic [1:0] right [DIGITS];
    logic [1:0] k;
    right = '{lock_cfg.code_first, lock_cfg.code_second, lock_cfg.code_third};
    while (code_len > 0 && $urandom_range(0, 3) != 0)
      send_event(CMD_BACKSPACE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    for (int i = 0; i < DIGITS; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_event(CMD_KEY, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        send_event(CMD_BACKSPACE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
      k = ($urandom_range(0, 3) != 0) ? right[code_len] : 2'($urandom_range(0, 3));
      send_event(CMD_KEY, k, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_servo(input int limit);
    int n;
    n = 0;
    do begin
      send_event(CMD_SERVO, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      n++;
    end while (travelling && n < limit);
  endtask

  task automatic run_seconds(input int limit);
    int n;
    n = 0;
    do begin
      send_event(CMD_SECOND, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      n++;
    end while (timer_on && n < limit);
  endtask

  task automatic drive_sessions(input int n);
    int stop_at;
    int pick;
    stop_at = sent_items + n;
    while (sent_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        enter_code();
      else if (pick < 55)
        run_servo(($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : stop_at - sent_items);
      else if (pick < 68)
        run_seconds(($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : stop_at - sent_items);
      else if (pick < 76)
        send_event(CMD_TOGGLE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      else if (pick < 86)
        send_event(CMD_REMOTE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      else if (pick < 92)
        send_event(CMD_BACKSPACE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      else
        send_event(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_unused_and_codes();
    send_event(CMD_SPARE_LO, 2'd3, 1'b1);
    send_event(CMD_SPARE_HI, 2'd0, 1'b0);
    send_event(CMD_BACKSPACE, 2'd2, 1'b0);
    send_event(CMD_KEY, 2'd0, 1'b0);
    send_event(CMD_BACKSPACE, 2'd1, 1'b1);
    repeat (3) send_event(CMD_KEY, RST_CODE_DIGIT, 1'b0);
    repeat (3) send_event(CMD_KEY, RST_CODE_DIGIT, 1'b1);
    send_event(CMD_KEY, 2'd2, 1'b0);
    send_event(CMD_KEY, 2'd3, 1'b0);
    send_event(CMD_KEY, 2'd0, 1'b0);
  endtask

  // Zero failure limit locks out on the first miss; zero code digit must match.
  task automatic test_door_and_lockout();
    load_settings('{code_first: 2'd0, code_second: 2'd3, code_third: 2'd2,
                    auto_close_seconds: 8'd0, max_failures: 3'd0,
                    closed_position: 8'd44, open_position: 8'd46});
    send_event(CMD_REMOTE, 2'd0, 1'b1);
    send_event(CMD_SERVO, 2'd0, 1'b0);
    send_event(CMD_SERVO, 2'd0, 1'b0);
    send_event(CMD_TOGGLE, 2'd0, 1'b0);
    send_event(CMD_SECOND, 2'd0, 1'b0);
    send_event(CMD_SERVO, 2'd0, 1'b0);
    send_event(CMD_KEY, 2'd0, 1'b0);
    send_event(CMD_KEY, 2'd3, 1'b0);
    send_event(CMD_KEY, 2'd2, 1'b0);
    send_event(CMD_KEY, 2'd1, 1'b1);
    send_event(CMD_KEY, 2'd2, 1'b1);
    send_event(CMD_KEY, 2'd3, 1'b1);
  endtask

  task automatic test_random_traffic();
    cfg_t s;
    for (int ph = 0; ph < 4; ph++) begin
      s = short_travel(ph == 1);
      case (ph)
        1: begin
          s.code_first = 2'($urandom_range(0, 3));
          s.code_second = 2'($urandom_range(0, 3));
          s.code_third = 2'($urandom_range(0, 3));
          s.auto_close_seconds = 8'd0;
          s.max_failures = 3'd0;
        end
        2: begin
          s.code_first = 2'($urandom_range(0, 3));
          s.auto_close_seconds = 8'($urandom_range(0, 7));
          s.max_failures = 3'($urandom_range(0, 7));
          s.open_position = s.closed_position + 8'($urandom_range(0, 3));
        end
        3: begin
          s.code_first = 2'd3;
          s.code_second = 2'd3;
          s.code_third = 2'd3;
          s.max_failures = 3'd7;
        end
        default: ;
      endcase
      load_settings(s);
      drive_sessions(170);
    end
  endtask

  task automatic test_extreme_positions();
    cfg_t s;
    s = short_travel(1'b0);
    s.auto_close_seconds = 8'd255;
    s.max_failures       = 3'd7;
    s.closed_position    = 8'd0;
    s.open_position      = 8'd255;
    load_settings(s);
    drive_sessions(120);
  endtask

  task automatic test_back_to_back();
    load_settings(short_travel(1'b0));
    max_wait = 0;
    drive_sessions(120);
    max_wait = 5;
  endtask

  task automatic test_drained_events();
    load_settings(short_travel(1'b0));
    repeat (40) begin
      send_event(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      wait_idle();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unused_and_codes();
    test_door_and_lockout();
    test_random_traffic();
    test_extreme_positions();
    test_back_to_back();
    test_drained_events();
    wait_idle();
    $display("Covered %0d events under %0d register settings, %0d status beats checked.",
             sent_items, settings_loaded, beats_checked);
    $display("Door opened by code %0d times, locked out %0d times, auto-closed %0d times.",
             opened_count, lockout_count, auto_close_count);
    if (mismatches == 0) begin
      $display("** keypad_code_lock_door_controller: PASSED **");
    end else begin
      $display("** keypad_code_lock_door_controller: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d status beats still outstanding", pending_status.size());
    $display("** keypad_code_lock_door_controller: FAILED **");
    $finish;
  end

endmodule
